### rtl/crw_pkg.sv
package crw_pkg;

  localparam int DataWidth = 32;
  localparam int SegWidth = 16;
  localparam int PeerWidth = 30;
  localparam int DupWidth = 16;
  localparam int AddrWidth = 4;
  localparam int DivSteps = DataWidth;
  localparam int DivCntWidth = $clog2(DivSteps);

  localparam logic [SegWidth-1:0] SegResetValue = 16'd1460;
  localparam logic [DataWidth-1:0] InitWindowReset = 32'd1460;
  localparam logic [DataWidth-1:0] InitThresholdReset = 32'd65535;
  localparam logic [DupWidth-1:0] DupMax = '1;
  localparam logic [DupWidth-1:0] DupFastRetransmit = 16'd3;

  typedef enum logic [1:0] {
    OP_NEW_ACK = 2'd0,
    OP_DUP_ACK = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_START   = 2'd3
  } crw_op_t;

  typedef enum logic [1:0] {
    REG_SEGMENT_SIZE      = 2'd0,
    REG_INITIAL_WINDOW    = 2'd1,
    REG_INITIAL_THRESHOLD = 2'd2
  } crw_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } crw_state_t;

  typedef struct packed {
    crw_op_t                operation;
    logic [PeerWidth-1:0]   peer_window;
  } crw_req_t;

  typedef struct packed {
    logic [DataWidth-1:0]   congestion_window;
    logic [DataWidth-1:0]   slow_start_threshold;
    logic                   retransmit_one;
    logic                   retransmit_all;
    logic                   restart_timer;
    logic                   try_send;
    logic [DupWidth-1:0]    duplicate_count;
  } crw_res_t;

  typedef struct packed {
    logic [SegWidth-1:0]    segment_size;
    logic [DataWidth-1:0]   initial_window;
    logic [DataWidth-1:0]   initial_threshold;
  } crw_cfg_t;

  function automatic logic [DataWidth-1:0] sat_add(input logic [DataWidth-1:0] a,
                                                   input logic [DataWidth-1:0] b);
    logic [DataWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataWidth] ? {DataWidth{1'b1}} : s[DataWidth-1:0];
  endfunction

endpackage

### rtl/crw_regs.sv
module crw_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crw_pkg::AddrWidth-1:0]   paddr,
  input  logic [crw_pkg::DataWidth-1:0]   pwdata,
  output logic [crw_pkg::DataWidth-1:0]   prdata,
  output logic                            pready,
  output crw_pkg::crw_cfg_t               cfg
);

  logic              wr_en;
  crw_pkg::crw_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = crw_pkg::crw_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_size      <= crw_pkg::SegResetValue;
      cfg.initial_window    <= crw_pkg::InitWindowReset;
      cfg.initial_threshold <= crw_pkg::InitThresholdReset;
    end else if (wr_en) begin
      case (reg_sel)
        crw_pkg::REG_SEGMENT_SIZE:      cfg.segment_size <= pwdata[crw_pkg::SegWidth-1:0];
        crw_pkg::REG_INITIAL_WINDOW:    cfg.initial_window <= pwdata;
        crw_pkg::REG_INITIAL_THRESHOLD: cfg.initial_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      crw_pkg::REG_SEGMENT_SIZE:
        prdata = {{(crw_pkg::DataWidth-crw_pkg::SegWidth){1'b0}}, cfg.segment_size};
      crw_pkg::REG_INITIAL_WINDOW:    prdata = cfg.initial_window;
      crw_pkg::REG_INITIAL_THRESHOLD: prdata = cfg.initial_threshold;
      default:                        prdata = '0;
    endcase
  end

endmodule

### rtl/crw_div.sv
module crw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [crw_pkg::DataWidth-1:0] dividend,
  input  logic [crw_pkg::DataWidth-1:0] divisor,
  output logic                          busy,
  output logic [crw_pkg::DataWidth-1:0] quotient
);

  logic [crw_pkg::DataWidth-1:0]   rem;
  logic [crw_pkg::DataWidth-1:0]   dvs;
  logic [crw_pkg::DivCntWidth-1:0] cnt;
  logic [crw_pkg::DataWidth:0]     trial;

  // restoring divide, one quotient bit per cycle through one subtractor
  assign trial = {rem, quotient[crw_pkg::DataWidth-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == crw_pkg::DivCntWidth'(crw_pkg::DivSteps - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[crw_pkg::DataWidth]) begin
        rem      <= trial[crw_pkg::DataWidth-1:0];
        quotient <= {quotient[crw_pkg::DataWidth-2:0], 1'b1};
      end else begin
        rem      <= {rem[crw_pkg::DataWidth-2:0], quotient[crw_pkg::DataWidth-1]};
        quotient <= {quotient[crw_pkg::DataWidth-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/tcp_reno_congestion_window.sv
// Start, timeout, duplicate ACK and new ACK outside congestion avoidance go from
//   ST_IDLE to ST_FINISH and register a result there once the result slot is free.
// A congestion avoidance new ACK goes through ST_MUL (multiply), ST_LOAD, a 32-step
//   single bit-serial divider in ST_DIV with a done check, then ST_FINISH.
// Requests are taken one at a time, only in ST_IDLE; a held result stalls the next one.
// Reset: synchronous; registers back to 1460/1460/65535, window 1460,
//   threshold 65535, duplicate count 0, no result pending.
module tcp_reno_congestion_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  crw_pkg::crw_req_t               req,
  output logic                            res_valid,
  input  logic                            res_ready,
  output crw_pkg::crw_res_t               res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crw_pkg::AddrWidth-1:0]   paddr,
  input  logic [crw_pkg::DataWidth-1:0]   pwdata,
  output logic [crw_pkg::DataWidth-1:0]   prdata,
  output logic                            pready
);

  localparam int DW = crw_pkg::DataWidth;
  localparam int SW = crw_pkg::SegWidth;

  crw_pkg::crw_cfg_t   cfg;
  crw_pkg::crw_state_t state, state_next;
  crw_pkg::crw_req_t   cur;

  logic [DW-1:0] window, window_next;
  logic [DW-1:0] threshold, threshold_next;
  logic [crw_pkg::DupWidth-1:0] dup_count, dup_next, dup_inc;
  logic [DW-1:0] sq;
  logic [DW-1:0] divisor;
  logic [DW-1:0] quotient;
  logic [DW-1:0] incr;
  logic [DW-1:0] seg_ext, seg_x2, seg_x3;
  logic [DW-1:0] flight, half, thr_calc;
  logic          div_busy;
  logic          accept, needs_div, commit, div_start, mul_en, slot_free;
  logic          r_one, r_all, r_timer, r_send;

  crw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign divisor = (window == '0) ? DW'(1) : window;

  crw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sq),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign accept    = req_valid && req_ready;
  assign slot_free = !res_valid || res_ready;
  assign needs_div = (req.operation == crw_pkg::OP_NEW_ACK) &&
                     (dup_count < crw_pkg::DupFastRetransmit) && !(window < threshold);

  always_comb begin
    state_next = state;
    unique case (state)
      crw_pkg::ST_IDLE:   if (req_valid) state_next = needs_div ? crw_pkg::ST_MUL
                                                              : crw_pkg::ST_FINISH;
      crw_pkg::ST_MUL:    state_next = crw_pkg::ST_LOAD;
      crw_pkg::ST_LOAD:   state_next = crw_pkg::ST_DIV;
      crw_pkg::ST_DIV:    if (!div_busy) state_next = crw_pkg::ST_FINISH;
      crw_pkg::ST_FINISH: if (slot_free) state_next = crw_pkg::ST_IDLE;
      default:            state_next = crw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state)
      crw_pkg::ST_IDLE:   req_ready = 1'b1;
      crw_pkg::ST_MUL:    mul_en = 1'b1;
      crw_pkg::ST_LOAD:   div_start = 1'b1;
      crw_pkg::ST_DIV:    ;
      crw_pkg::ST_FINISH: commit = slot_free;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (mul_en) begin
      sq <= {{(DW-SW){1'b0}}, cfg.segment_size} * {{(DW-SW){1'b0}}, cfg.segment_size};
    end
  end

  assign seg_ext  = {{(DW-SW){1'b0}}, cfg.segment_size};
  assign seg_x2   = {{(DW-SW-1){1'b0}}, cfg.segment_size, 1'b0};
  assign seg_x3   = seg_ext + seg_x2;
  assign flight   = (window < {2'b00, cur.peer_window}) ? window : {2'b00, cur.peer_window};
  assign half     = {1'b0, flight[DW-1:1]};
  assign thr_calc = (half > seg_x2) ? half : seg_x2;
  assign incr     = (quotient == '0) ? DW'(1) : quotient;
  assign dup_inc  = (dup_count == crw_pkg::DupMax) ? dup_count : dup_count + 1'b1;

  always_comb begin
    window_next    = window;
    threshold_next = threshold;
    dup_next       = dup_count;
    r_one          = 1'b0;
    r_all          = 1'b0;
    r_timer        = 1'b0;
    r_send         = 1'b0;
    case (cur.operation)
      crw_pkg::OP_NEW_ACK: begin
        if (dup_count >= crw_pkg::DupFastRetransmit) begin
          window_next = threshold;
        end else if (window < threshold) begin
          window_next = crw_pkg::sat_add(window, seg_ext);
        end else begin
          window_next = crw_pkg::sat_add(window, incr);
        end
        dup_next = '0;
        r_send   = 1'b1;
      end
      crw_pkg::OP_DUP_ACK: begin
        dup_next = dup_inc;
        if (dup_inc == crw_pkg::DupFastRetransmit) begin
          threshold_next = thr_calc;
          window_next    = crw_pkg::sat_add(thr_calc, seg_x3);
          r_one          = 1'b1;
          r_timer        = 1'b1;
        end else if (dup_inc > crw_pkg::DupFastRetransmit) begin
          window_next = crw_pkg::sat_add(window, seg_ext);
          r_send      = 1'b1;
        end
      end
      crw_pkg::OP_TIMEOUT: begin
        threshold_next = thr_calc;
        window_next    = seg_ext;
        dup_next       = '0;
        r_all          = 1'b1;
      end
      default: begin
        window_next    = cfg.initial_window;
        threshold_next = cfg.initial_threshold;
        dup_next       = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= crw_pkg::InitWindowReset;
      threshold <= crw_pkg::InitThresholdReset;
      dup_count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (commit) begin
        window    <= window_next;
        threshold <= threshold_next;
        dup_count <= dup_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.congestion_window    <= window_next;
      res.slow_start_threshold <= threshold_next;
      res.retransmit_one       <= r_one;
      res.retransmit_all       <= r_all;
      res.restart_timer        <= r_timer;
      res.try_send             <= r_send;
      res.duplicate_count      <= dup_next;
    end
  end

endmodule

### tb/sv/tb_tcp_reno_congestion_window.sv
module tb_tcp_reno_congestion_window;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                clk;
  logic                                rst;
  logic                                req_valid;
  logic                                req_ready;
  crw_pkg::crw_req_t                   req;
  logic                                res_valid;
  logic                                res_ready;
  crw_pkg::crw_res_t                   res;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [crw_pkg::AddrWidth-1:0]       paddr;
  logic [crw_pkg::DataWidth-1:0]       pwdata;
  logic [crw_pkg::DataWidth-1:0]       prdata;
  logic                                pready;

  tcp_reno_congestion_window dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow of the window engine
  logic [crw_pkg::SegWidth-1:0]  mss_cfg = crw_pkg::SegResetValue;
  logic [crw_pkg::DataWidth-1:0] init_cwnd_cfg = crw_pkg::InitWindowReset;
  logic [crw_pkg::DataWidth-1:0] init_ssthresh_cfg = crw_pkg::InitThresholdReset;
  logic [crw_pkg::DataWidth-1:0] cwnd_m = crw_pkg::InitWindowReset;
  logic [crw_pkg::DataWidth-1:0] ssthresh_m = crw_pkg::InitThresholdReset;
  logic [crw_pkg::DupWidth-1:0]  dup_m = '0;

  crw_pkg::crw_res_t window_updates[$];
  int                mismatch_count = 0;
  int                requests_sent = 0;
  int                ready_hold = 0;
  bit                steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("tcp_reno_congestion_window verification failed");
    $finish;
  end

  function automatic logic [crw_pkg::DataWidth-1:0] clamp_add(
      logic [crw_pkg::DataWidth-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > 64'hFFFF_FFFF) ? '1 : s[crw_pkg::DataWidth-1:0];
  endfunction

  function automatic void new_threshold(logic [crw_pkg::PeerWidth-1:0] peer);
    logic [crw_pkg::DataWidth-1:0] flight;
    logic [crw_pkg::DataWidth-1:0] floor2;
    flight = (cwnd_m < 32'(peer)) ? cwnd_m : 32'(peer);
    floor2 = 32'(mss_cfg) * 32'd2;
    ssthresh_m = ((flight >> 1) > floor2) ? (flight >> 1) : floor2;
  endfunction

  function automatic crw_pkg::crw_res_t reno_step(crw_pkg::crw_req_t r);
    crw_pkg::crw_res_t             o;
    logic [63:0]                   incr;
    logic [crw_pkg::DataWidth-1:0] divisor;
    o = '0;
    case (r.operation)
      crw_pkg::OP_NEW_ACK: begin
        if (dup_m >= crw_pkg::DupFastRetransmit) begin
          cwnd_m = ssthresh_m;
        end else if (cwnd_m < ssthresh_m) begin
          cwnd_m = clamp_add(cwnd_m, 64'(mss_cfg));
        end else begin
          divisor = (cwnd_m == '0) ? 32'd1 : cwnd_m;
          incr = (64'(mss_cfg) * 64'(mss_cfg)) / 64'(divisor);
          if (incr == 64'd0) incr = 64'd1;
          cwnd_m = clamp_add(cwnd_m, incr);
        end
        dup_m = '0;
        o.try_send = 1'b1;
      end
      crw_pkg::OP_DUP_ACK: begin
        if (dup_m != crw_pkg::DupMax) dup_m = dup_m + 1'b1;
        if (dup_m == crw_pkg::DupFastRetransmit) begin
          new_threshold(r.peer_window);
          cwnd_m = clamp_add(ssthresh_m, 64'(mss_cfg) * 64'd3);
          o.retransmit_one = 1'b1;
          o.restart_timer = 1'b1;
        end else if (dup_m > crw_pkg::DupFastRetransmit) begin
          cwnd_m = clamp_add(cwnd_m, 64'(mss_cfg));
          o.try_send = 1'b1;
        end
      end
      crw_pkg::OP_TIMEOUT: begin
        new_threshold(r.peer_window);
        cwnd_m = 32'(mss_cfg);
        dup_m = '0;
        o.retransmit_all = 1'b1;
      end
      default: begin
        cwnd_m = init_cwnd_cfg;
        ssthresh_m = init_ssthresh_cfg;
        dup_m = '0;
      end
    endcase
    o.congestion_window = cwnd_m;
    o.slow_start_threshold = ssthresh_m;
    o.duplicate_count = dup_m;
    return o;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0h got %0h", $realtime, what, want, got);
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  task automatic check_result(crw_pkg::crw_res_t got);
    crw_pkg::crw_res_t want;
    if (window_updates.size() == 0) begin
      note_mismatch("unrequested result", '0, 64'(got.congestion_window));
    end else begin
      want = window_updates.pop_front();
      check_field("congestion_window", want.congestion_window, got.congestion_window);
      check_field("slow_start_threshold", want.slow_start_threshold,
                  got.slow_start_threshold);
      check_field("retransmit_one", want.retransmit_one, got.retransmit_one);
      check_field("retransmit_all", want.retransmit_all, got.retransmit_all);
      check_field("restart_timer", want.restart_timer, got.restart_timer);
      check_field("try_send", want.try_send, got.try_send);
      check_field("duplicate_count", want.duplicate_count, got.duplicate_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) check_result(res);
      if (req_valid && req_ready) window_updates.push_back(reno_step(req));
    end
  end

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        res_ready <= 1'b0;
        ready_hold--;
      end else begin
        res_ready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  function automatic int idle_gap();
    if (steady || $urandom_range(99) >= 13) return 0;
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [crw_pkg::PeerWidth-1:0] rand_peer();
    case ($urandom_range(3))
      0: return crw_pkg::PeerWidth'($urandom);
      1: return crw_pkg::PeerWidth'($urandom_range(65535));
      2: return crw_pkg::PeerWidth'($urandom_range(2000000));
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_request(crw_pkg::crw_op_t op, logic [crw_pkg::PeerWidth-1:0] peer);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{operation: op, peer_window: peer};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_block();
    @(negedge clk);
    req_valid <= 1'b0;
    while (window_updates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(crw_pkg::crw_reg_t idx, logic [crw_pkg::DataWidth-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      crw_pkg::REG_SEGMENT_SIZE:      mss_cfg = value[crw_pkg::SegWidth-1:0];
      crw_pkg::REG_INITIAL_WINDOW:    init_cwnd_cfg = value;
      crw_pkg::REG_INITIAL_THRESHOLD: init_ssthresh_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(crw_pkg::crw_reg_t idx, logic [crw_pkg::DataWidth-1:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("register readback", want, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_params(logic [crw_pkg::DataWidth-1:0] mss,
                            logic [crw_pkg::DataWidth-1:0] iw,
                            logic [crw_pkg::DataWidth-1:0] it);
    drain_block();
    set_reg(crw_pkg::REG_SEGMENT_SIZE, mss);
    set_reg(crw_pkg::REG_INITIAL_WINDOW, iw);
    set_reg(crw_pkg::REG_INITIAL_THRESHOLD, it);
  endtask

  task automatic test_register_access();
    logic [crw_pkg::DataWidth-1:0] a, b, c;
    check_reg(crw_pkg::REG_SEGMENT_SIZE, 32'(crw_pkg::SegResetValue));
    check_reg(crw_pkg::REG_INITIAL_WINDOW, crw_pkg::InitWindowReset);
    check_reg(crw_pkg::REG_INITIAL_THRESHOLD, crw_pkg::InitThresholdReset);
    a = $urandom;
    b = $urandom;
    c = $urandom;
    set_params(a, b, c);
    check_reg(crw_pkg::REG_SEGMENT_SIZE, {16'd0, a[crw_pkg::SegWidth-1:0]});
    check_reg(crw_pkg::REG_INITIAL_WINDOW, b);
    check_reg(crw_pkg::REG_INITIAL_THRESHOLD, c);
    set_params(~a, ~b, ~c);
    check_reg(crw_pkg::REG_SEGMENT_SIZE, {16'd0, ~a[crw_pkg::SegWidth-1:0]});
    check_reg(crw_pkg::REG_INITIAL_WINDOW, ~b);
    check_reg(crw_pkg::REG_INITIAL_THRESHOLD, ~c);
    set_params(32'(crw_pkg::SegResetValue), crw_pkg::InitWindowReset,
               crw_pkg::InitThresholdReset);
  endtask

  task automatic test_directed();
    // window from reset, slow start, then a loss episode
    send_request(crw_pkg::OP_NEW_ACK, 30'd100000);
    send_request(crw_pkg::OP_NEW_ACK, '1);
    repeat (3) send_request(crw_pkg::OP_DUP_ACK, 30'd5000);
    send_request(crw_pkg::OP_DUP_ACK, '0);
    send_request(crw_pkg::OP_NEW_ACK, '0);
    send_request(crw_pkg::OP_TIMEOUT, '0);
    send_request(crw_pkg::OP_TIMEOUT, '1);
    send_request(crw_pkg::OP_START, '0);
    // zero segment size and zero window
    set_params('0, '0, '0);
    send_request(crw_pkg::OP_START, '1);
    send_request(crw_pkg::OP_NEW_ACK, '1);
    send_request(crw_pkg::OP_NEW_ACK, 30'd12345);
    repeat (3) send_request(crw_pkg::OP_DUP_ACK, '1);
    send_request(crw_pkg::OP_TIMEOUT, '1);
    // saturating sums
    set_params(32'hFFFF_FFFF, 32'hFFFF_FFF0, '1);
    send_request(crw_pkg::OP_START, '0);
    send_request(crw_pkg::OP_NEW_ACK, '0);
    send_request(crw_pkg::OP_NEW_ACK, '1);
    repeat (2) send_request(crw_pkg::OP_DUP_ACK, '1);
    send_request(crw_pkg::OP_TIMEOUT, '1);
  endtask

  task automatic test_backpressure();
    int i;
    set_params(32'd1460, 32'd1460, 32'd8000);
    send_request(crw_pkg::OP_START, '0);
    ready_hold = 300;
    for (i = 0; i < 24; i++)
      send_request((i % 4 == 3) ? crw_pkg::OP_DUP_ACK : crw_pkg::OP_NEW_ACK, rand_peer());
  endtask

  task automatic pick_settings(int phase);
    logic [crw_pkg::SegWidth-1:0]  mss;
    logic [crw_pkg::DataWidth-1:0] iw, it;
    case (phase)
      0: mss = 16'd1;
      5: mss = '1;
      default: mss = ($urandom_range(3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(536, 9000));
    endcase
    case ($urandom_range(3))
      0: iw = 32'(mss) * $urandom_range(1, 10);
      1: iw = $urandom;
      2: iw = 32'hFFFF_FFFF - $urandom_range(100000);
      default: iw = $urandom_range(10);
    endcase
    case ($urandom_range(3))
      0: it = 32'(mss) * $urandom_range(2, 64);
      1: it = $urandom;
      2: it = '1;
      default: it = $urandom_range(3);
    endcase
    set_params({16'($urandom), mss}, iw, it);
    send_request(crw_pkg::OP_START, rand_peer());
  endtask

  task automatic run_traffic(int count);
    int first;
    int kind;
    int n;
    first = requests_sent;
    while (requests_sent - first < count) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        repeat ($urandom_range(1, 12)) send_request(crw_pkg::OP_NEW_ACK, rand_peer());
      end else if (kind < 70) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        repeat (n) send_request(crw_pkg::OP_DUP_ACK, rand_peer());
        send_request(crw_pkg::OP_NEW_ACK, rand_peer());
      end else if (kind < 80) begin
        send_request(crw_pkg::OP_TIMEOUT, rand_peer());
        repeat ($urandom_range(4)) send_request(crw_pkg::OP_NEW_ACK, rand_peer());
      end else if (kind < 85) begin
        send_request(crw_pkg::OP_START, rand_peer());
      end else begin
        send_request(crw_pkg::crw_op_t'($urandom_range(3)), rand_peer());
      end
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      pick_settings(phase);
      steady = (phase == 2);
      run_traffic(200);
      steady = 1'b0;
    end
  endtask

  task automatic test_long_dup_run();
    int i;
    set_params(32'd1, 32'd100, 32'd50000);
    steady = 1'b1;
    send_request(crw_pkg::OP_START, '0);
    for (i = 0; i < 60; i++)
      send_request(crw_pkg::OP_DUP_ACK, crw_pkg::PeerWidth'($urandom));
    send_request(crw_pkg::OP_NEW_ACK, 30'd1000);
    drain_block();
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed();
    test_backpressure();
    test_random_traffic();
    test_long_dup_run();
    drain_block();
    if (mismatch_count == 0 && window_updates.size() == 0) begin
      $display("tcp_reno_congestion_window verification clean");
    end else begin
      $display("tcp_reno_congestion_window verification failed");
    end
    $finish;
  end

endmodule
